[sv/rotated_rect_overlap_test_unit_assert.svh]
//------------------------------------------------------------------------------
// Assertion macros for the rotated rectangle overlap test unit
// Shared concurrent assertion forms used by the top pipeline module.
//------------------------------------------------------------------------------
`ifndef ROTATED_RECT_OVERLAP_TEST_UNIT_ASSERT_SVH
`define ROTATED_RECT_OVERLAP_TEST_UNIT_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define RRO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// The expression must hold in every cycle outside reset.
`define RRO_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

`endif

[sv/rro_pkg.sv]
//------------------------------------------------------------------------------
// Rotated rectangle overlap package
// Constants, types and the CORDIC arctangent table shared by the pipeline.
//------------------------------------------------------------------------------
package rro_pkg;
	localparam int CordicStepsDef = 16;
	localparam int TabLen = 24;
	localparam logic signed [26:0] GainQ24 = 27'sd10188014;
	localparam logic signed [21:0] TwoPiQ16 = 22'sd411775;
	localparam logic signed [21:0] PiQ16 = 22'sd205887;
	localparam logic signed [21:0] HalfPiQ16 = 22'sd102944;
	localparam int ModQuarter = 15708;
	localparam int ModHalf = 31416;
	// The rounded angle difference never exceeds ten quarter-turn multiples.
	localparam int QuarterMax = 10;

	function automatic logic signed [21:0] atan_q16(input int i);
		logic signed [21:0] t;
		case (i)
			0: t = 22'sd51472;
			1: t = 22'sd30386;
			2: t = 22'sd16055;
			3: t = 22'sd8150;
			4: t = 22'sd4091;
			5: t = 22'sd2047;
			6: t = 22'sd1024;
			7: t = 22'sd512;
			8: t = 22'sd256;
			9: t = 22'sd128;
			10: t = 22'sd64;
			11: t = 22'sd32;
			12: t = 22'sd16;
			13: t = 22'sd8;
			14: t = 22'sd4;
			15: t = 22'sd2;
			16: t = 22'sd1;
			default: t = 22'sd0;
		endcase
		return t;
	endfunction

	typedef struct packed {
		logic signed [34:0] dx;
		logic signed [34:0] dy;
		logic [31:0] wa;
		logic [31:0] ha;
		logic [31:0] wb;
		logic [31:0] hb;
		logic signed [20:0] ra;
		logic signed [20:0] d;
	} geom_t;
endpackage

[sv/rro_cordic.sv]
//------------------------------------------------------------------------------
// Pipelined CORDIC sine and cosine
// Reduces a Q16 angle into range and rotates one micro-step per stage.
//------------------------------------------------------------------------------
module rro_cordic
	import rro_pkg::*;
#(
	parameter int CORDIC_STEPS = CordicStepsDef,
	parameter int TagW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic signed [20:0] angle,
	input  logic [TagW-1:0] tag_in,
	output logic out_valid,
	output logic signed [26:0] cos_q24,
	output logic signed [26:0] sin_q24,
	output logic [TagW-1:0] tag_out
);
	localparam int N = CORDIC_STEPS;
	localparam int Wraps = 3;

	logic signed [21:0] a0, a1, a2;
	logic neg0;
	logic v_s [0:N];
	logic signed [27:0] x_s [0:N];
	logic signed [27:0] y_s [0:N];
	logic signed [21:0] z_s [0:N];
	logic n_s [0:N];
	logic [TagW-1:0] t_s [0:N];

	always_comb begin
		a0 = 22'(angle);
		a1 = a0;
		for (int r = 0; r < Wraps; r++) begin
			if (a1 > PiQ16) begin
				a1 = a1 - TwoPiQ16;
			end else if (a1 < -PiQ16) begin
				a1 = a1 + TwoPiQ16;
			end
		end
		neg0 = 1'b0;
		a2 = a1;
		if (a1 > HalfPiQ16) begin
			a2 = a1 - PiQ16;
			neg0 = 1'b1;
		end else if (a1 < -HalfPiQ16) begin
			a2 = a1 + PiQ16;
			neg0 = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0] <= 28'(GainQ24);
		y_s[0] <= '0;
		z_s[0] <= a2;
		n_s[0] <= neg0;
		t_s[0] <= tag_in;
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_q16(i);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_q16(i);
			end
			n_s[i+1] <= n_s[i];
			t_s[i+1] <= t_s[i];
		end
	end

	assign out_valid = v_s[N];
	assign cos_q24 = n_s[N] ? 27'(-x_s[N]) : 27'(x_s[N]);
	assign sin_q24 = n_s[N] ? 27'(-y_s[N]) : 27'(y_s[N]);
	assign tag_out = t_s[N];
endmodule

[sv/rro_rotate.sv]
//------------------------------------------------------------------------------
// Center rotation stages
// Rotates the center offset of the second rectangle by minus the first angle.
//------------------------------------------------------------------------------
module rro_rotate
	import rro_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  geom_t g_in,
	input  logic signed [26:0] c,
	input  logic signed [26:0] s,
	output logic out_valid,
	output geom_t g_out
);
	logic v_s1, v_s2;
	geom_t g_s1, g_s2, g_nx;
	logic signed [60:0] p0_s1, p1_s1, p2_s1, p3_s1;
	logic signed [61:0] rx, ry;
	logic signed [33:0] dx2, dy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		rx = 62'(p0_s1) + 62'(p1_s1) + 62'sd8388608;
		ry = 62'(p2_s1) - 62'(p3_s1) + 62'sd8388608;
		dx2 = (g_s1.ra != 0) ? 34'(rx >>> 24) : 34'(g_s1.dx);
		dy2 = (g_s1.ra != 0) ? 34'(ry >>> 24) : 34'(g_s1.dy);
		g_nx = g_s1;
		g_nx.dx = {dx2, 1'b0};
		g_nx.dy = {dy2, 1'b0};
	end

	always_ff @(posedge clk) begin
		p0_s1 <= 61'(g_in.dx) * 61'(c);
		p1_s1 <= 61'(g_in.dy) * 61'(s);
		p2_s1 <= 61'(g_in.dy) * 61'(c);
		p3_s1 <= 61'(g_in.dx) * 61'(s);
		g_s1 <= g_in;
		g_s2 <= g_nx;
	end

	assign out_valid = v_s2;
	assign g_out = g_s2;
endmodule

[sv/rro_sat.sv]
//------------------------------------------------------------------------------
// Separating axis decision stages
// Takes the relative-angle class from its inputs and runs the box or projection tests.
//------------------------------------------------------------------------------
module rro_sat
	import rro_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  geom_t g,
	input  logic aligned,
	input  logic swapped,
	input  logic signed [26:0] c,
	input  logic signed [26:0] s,
	output logic out_valid,
	output logic hit
);
	logic [34:0] adx, ady;
	logic [26:0] ac, as_;
	logic v_s1, v_s2, v_s3;
	logic box_s1, al_s1;
	logic [34:0] adx_s1, ady_s1;
	logic [31:0] wa_s1, ha_s1, wb_s1, hb_s1;
	logic [58:0] wbac_s1, wbas_s1, hbac_s1, hbas_s1, waac_s1, waas_s1, haac_s1, haas_s1;
	logic signed [60:0] cdy_s1, sdx_s1, cdx_s1, sdy_s1;
	logic box_s2, al_s2, t0_s2, t1_s2;
	logic [62:0] l2_s2, l3_s2;
	logic [61:0] pa_s2, pb_s2;
	logic hit_s3;
	logic [32:0] ew, eh;
	logic signed [61:0] pa, pb;
	logic [60:0] l0, l1;

	always_comb begin
		adx = g.dx[34] ? 35'(-g.dx) : 35'(g.dx);
		ady = g.dy[34] ? 35'(-g.dy) : 35'(g.dy);
		ac = c[26] ? 27'(-c) : 27'(c);
		as_ = s[26] ? 27'(-s) : 27'(s);
		ew = swapped ? {1'b0, g.hb} : {1'b0, g.wb};
		eh = swapped ? {1'b0, g.wb} : {1'b0, g.hb};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		al_s1 <= aligned;
		box_s1 <= !((adx > 35'(g.wa) + 35'(ew)) || (ady > 35'(g.ha) + 35'(eh)));
		adx_s1 <= adx;
		ady_s1 <= ady;
		wa_s1 <= g.wa;
		ha_s1 <= g.ha;
		wb_s1 <= g.wb;
		hb_s1 <= g.hb;
		wbac_s1 <= g.wb * ac;
		wbas_s1 <= g.wb * as_;
		hbac_s1 <= g.hb * ac;
		hbas_s1 <= g.hb * as_;
		waac_s1 <= g.wa * ac;
		waas_s1 <= g.wa * as_;
		haac_s1 <= g.ha * ac;
		haas_s1 <= g.ha * as_;
		cdy_s1 <= 61'(c) * 61'(g.dy);
		sdx_s1 <= 61'(s) * 61'(g.dx);
		cdx_s1 <= 61'(c) * 61'(g.dx);
		sdy_s1 <= 61'(s) * 61'(g.dy);
	end

	always_comb begin
		l0 = {29'd0, wa_s1} << 24;
		l1 = {29'd0, ha_s1} << 24;
		pa = 62'(cdy_s1) - 62'(sdx_s1);
		pb = 62'(cdx_s1) + 62'(sdy_s1);
	end

	always_ff @(posedge clk) begin
		box_s2 <= box_s1;
		al_s2 <= al_s1;
		t0_s2 <= (63'({adx_s1, 24'd0})) > (63'(l0) + 63'(wbac_s1) + 63'(hbas_s1));
		t1_s2 <= (63'({ady_s1, 24'd0})) > (63'(l1) + 63'(wbas_s1) + 63'(hbac_s1));
		l2_s2 <= 63'({hb_s1, 24'd0}) + 63'(waas_s1) + 63'(haac_s1);
		l3_s2 <= 63'({wb_s1, 24'd0}) + 63'(waac_s1) + 63'(haas_s1);
		pa_s2 <= pa[61] ? 62'(-pa) : 62'(pa);
		pb_s2 <= pb[61] ? 62'(-pb) : 62'(pb);
	end

	always_ff @(posedge clk) begin
		if (al_s2) begin
			hit_s3 <= box_s2;
		end else begin
			hit_s3 <= !(t0_s2 || t1_s2 || 63'(pa_s2) > l2_s2 || 63'(pb_s2) > l3_s2);
		end
	end

	assign out_valid = v_s3;
	assign hit = hit_s3;
endmodule

[sv/rotated_rect_overlap_test_unit.sv]
// An accepted start reaches done through two CORDIC passes, rotation and decision
// stages in one pipeline.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// The result strobe done carries overlap for one cycle; the receiver cannot stall.
// Reset clears all valid bits asynchronously; data registers are not reset.
//------------------------------------------------------------------------------
// Rotated rectangle overlap test unit
// Fully pipelined separating axis overlap test for two rotated rectangles.
//------------------------------------------------------------------------------
`include "rotated_rect_overlap_test_unit_assert.svh"
module rotated_rect_overlap_test_unit
	import rro_pkg::*;
#(
	parameter int CORDIC_STEPS = CordicStepsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [31:0] center_x_a,
	input  logic signed [31:0] center_y_a,
	input  logic [31:0] width_a,
	input  logic [31:0] height_a,
	input  logic signed [19:0] angle_a,
	input  logic signed [31:0] center_x_b,
	input  logic signed [31:0] center_y_b,
	input  logic [31:0] width_b,
	input  logic [31:0] height_b,
	input  logic signed [19:0] angle_b,
	output logic done,
	output logic overlap
);
	localparam int GW = $bits(geom_t);

	geom_t g0, g1, g2, g3;
	logic v1, v2, v3, v4, al, sw, al2, sw2;
	logic signed [26:0] c1, s1, c2, s2;
	logic [GW+1:0] t2;
	logic [20:0] d0, dm;
	logic [35:0] prod_s1;
	logic [19:0] m;
	logic v_s1;
	geom_t g_s1;

	assign busy = 1'b0;

	always_comb begin
		g0.dx = 35'(center_x_b) - 35'(center_x_a);
		g0.dy = 35'(center_y_b) - 35'(center_y_a);
		g0.wa = width_a;
		g0.ha = height_a;
		g0.wb = width_b;
		g0.hb = height_b;
		g0.ra = 21'(angle_a);
		g0.d = 21'(angle_b) - 21'(angle_a);
	end

	rro_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .TagW(GW)) u_cordic_a (
		.clk, .arst_n, .in_valid(start), .angle(g0.ra), .tag_in(g0),
		.out_valid(v1), .cos_q24(c1), .sin_q24(s1), .tag_out(g1)
	);

	rro_rotate u_rotate (
		.clk, .arst_n, .in_valid(v1), .g_in(g1), .c(c1), .s(s1),
		.out_valid(v2), .g_out(g2)
	);

	always_comb begin
		d0 = g2.d[20] ? 21'(-g2.d) : 21'(g2.d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= v2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 36'(d0) * 36'd10000 + 36'd32768;
		g_s1 <= g2;
	end

	always_comb begin
		m = prod_s1[35:16];
		al = 1'b0;
		sw = 1'b0;
		for (int k = 0; k <= QuarterMax; k++) begin
			if (m == 20'(k * ModQuarter)) begin
				al = 1'b1;
				sw = 1'(k);
			end
		end
		dm = g_s1.d;
	end

	rro_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .TagW(GW + 2)) u_cordic_d (
		.clk, .arst_n, .in_valid(v_s1), .angle(dm), .tag_in({g_s1, al, sw}),
		.out_valid(v3), .cos_q24(c2), .sin_q24(s2), .tag_out(t2)
	);

	assign g3 = t2[GW+1:2];
	assign al2 = t2[1];
	assign sw2 = t2[0];

	rro_sat u_sat (
		.clk, .arst_n, .in_valid(v3), .g(g3), .aligned(al2), .swapped(sw2),
		.c(c2), .s(s2), .out_valid(v4), .hit(overlap)
	);

	assign done = v4;

	`RRO_ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy)
	`RRO_ASSERT_ALWAYS(a_done_known, clk, arst_n, !$isunknown(done))
	`RRO_ASSERT_NEXT(a_mid_to_cordic, clk, arst_n, v2, v_s1)
endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Rotated rectangle overlap test unit bench
// Drives rectangle pairs through the unit, predicts the overlap flag with a
// fixed-point separating axis model and compares each done strobe in order.
//------------------------------------------------------------------------------
module tb
	import rro_pkg::*;
();

	localparam int Steps = 16;
	localparam int Latency = 2 * Steps + 7;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [31:0] center_x_a, center_y_a, center_x_b, center_y_b;
	logic [31:0] width_a, height_a, width_b, height_b;
	logic signed [19:0] angle_a, angle_b;
	logic done;
	logic overlap;

	typedef struct {
		logic signed [31:0] xa, ya, xb, yb;
		logic [31:0] wa, ha, wb, hb;
		logic signed [19:0] ra, rb;
	} pair_t;

	bit overlap_queue[$];
	int mismatches = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int hits_seen = 0;
	bit gaps_on = 1;

	rotated_rect_overlap_test_unit #(.CORDIC_STEPS(Steps)) i_dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint absval(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic int atan_tab(int i);
		int t [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2, 1};
		return i < 17 ? t[i] : 0;
	endfunction

	task automatic cordic_trig(input longint ang, output longint c, output longint s);
		longint x, y, z, xs, ys;
		bit flip;
		x = 10188014;
		y = 0;
		flip = 0;
		while (ang > 205887) ang -= 411775;
		while (ang < -205887) ang += 411775;
		if (ang > 102944) begin
			ang -= 205887;
			flip = 1;
		end else if (ang < -102944) begin
			ang += 205887;
			flip = 1;
		end
		z = ang;
		for (int i = 0; i < Steps; i++) begin
			xs = shr_floor(x, i);
			ys = shr_floor(y, i);
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(atan_tab(i));
			end else begin
				x += ys; y -= xs; z += longint'(atan_tab(i));
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic predict_overlap(input pair_t p, output bit hit);
		longint dx, dy, wa, ha, wb, hb, d, m, c, s, ac, as_, lim, rx, ry, ew, eh;
		wa = p.wa; ha = p.ha; wb = p.wb; hb = p.hb;
		dx = longint'(p.xb) - longint'(p.xa);
		dy = longint'(p.yb) - longint'(p.ya);
		if (p.ra != 0) begin
			cordic_trig(p.ra, c, s);
			rx = dx * c + dy * s;
			ry = dy * c - dx * s;
			dx = shr_floor(rx + (64'sd1 <<< 23), 24);
			dy = shr_floor(ry + (64'sd1 <<< 23), 24);
		end
		dx *= 2;
		dy *= 2;
		d = longint'(p.rb) - longint'(p.ra);
		m = (absval(d * 10000) + 32768) >>> 16;
		if (m % ModQuarter == 0) begin
			ew = (m % ModHalf != 0) ? hb : wb;
			eh = (m % ModHalf != 0) ? wb : hb;
			hit = !(absval(dx) > wa + ew || absval(dy) > ha + eh);
		end else begin
			cordic_trig(d, c, s);
			ac = absval(c);
			as_ = absval(s);
			hit = 1;
			lim = (wa <<< 24) + wb * ac + hb * as_;
			if ((absval(dx) <<< 24) > lim) hit = 0;
			lim = (ha <<< 24) + wb * as_ + hb * ac;
			if ((absval(dy) <<< 24) > lim) hit = 0;
			lim = (hb <<< 24) + wa * as_ + ha * ac;
			if (absval(c * dy - s * dx) > lim) hit = 0;
			lim = (wb <<< 24) + wa * ac + ha * as_;
			if (absval(c * dx + s * dy) > lim) hit = 0;
		end
	endtask

	task automatic send_request(input pair_t p);
		bit hit;
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 0;
			gap = $urandom_range(1, 17);
			repeat (gap) @(negedge clk);
		end
		start <= 1;
		center_x_a <= p.xa; center_y_a <= p.ya; width_a <= p.wa; height_a <= p.ha;
		angle_a <= p.ra; center_x_b <= p.xb; center_y_b <= p.yb; width_b <= p.wb;
		height_b <= p.hb; angle_b <= p.rb;
		predict_overlap(p, hit);
		@(posedge clk);
		while (busy) @(posedge clk);
		overlap_queue.push_back(hit);
		requests_sent++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			hits_seen += overlap;
			if (overlap_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result, overlap=%0b", overlap);
			end else begin
				bit want;
				want = overlap_queue.pop_front();
				if (want !== overlap) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch on result %0d: expected overlap=%0b, got %0b",
							results_seen, want, overlap);
				end
			end
		end
	end

	function automatic logic signed [19:0] pick_angle();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 20'(($urandom_range(0, 8) - 4) * 102944);
			2: return 20'($urandom_range(0, 411775) - 205887);
			default: return 20'($urandom);
		endcase
	endfunction

	function automatic pair_t random_pair(bit near);
		pair_t p;
		if (near) begin
			p.xa = 32'($urandom_range(0, 4000000)) - 32'sd2000000;
			p.ya = 32'($urandom_range(0, 4000000)) - 32'sd2000000;
			p.xb = p.xa + 32'($urandom_range(0, 2000000)) - 32'sd1000000;
			p.yb = p.ya + 32'($urandom_range(0, 2000000)) - 32'sd1000000;
			p.wa = $urandom_range(0, 800000); p.ha = $urandom_range(0, 800000);
			p.wb = $urandom_range(0, 800000); p.hb = $urandom_range(0, 800000);
		end else begin
			p.xa = $urandom; p.ya = $urandom; p.xb = $urandom; p.yb = $urandom;
			p.wa = $urandom; p.ha = $urandom; p.wb = $urandom; p.hb = $urandom;
		end
		p.ra = pick_angle();
		p.rb = ($urandom_range(0, 3) == 0) ? p.ra + 20'(($urandom_range(0, 4) - 2) * 102944)
			: pick_angle();
		return p;
	endfunction

	task automatic wait_drained();
		start <= 0;
		while (overlap_queue.size() != 0) @(negedge clk);
		repeat (Latency + 4) @(negedge clk);
	endtask

	task automatic test_directed();
		pair_t p;
		p = '{default: 0};
		send_request(p);
		p.wa = 32'hFFFF_FFFF; p.ha = 32'hFFFF_FFFF; p.wb = 32'hFFFF_FFFF; p.hb = 32'hFFFF_FFFF;
		p.xa = 32'sh8000_0000; p.ya = 32'sh8000_0000;
		p.xb = 32'sh7FFF_FFFF; p.yb = 32'sh7FFF_FFFF;
		send_request(p);
		p.ra = 20'sh80000; p.rb = 20'sh7FFFF;
		send_request(p);
		p = '{default: 0};
		p.wa = 65536; p.ha = 65536; p.wb = 65536; p.hb = 65536;
		p.xb = 131072;
		send_request(p);
		p.xb = 131073;
		send_request(p);
		p.xb = 0; p.wb = 0; p.hb = 0;
		send_request(p);
		for (int k = -4; k <= 4; k++) begin
			p = '{default: 0};
			p.wa = 200000; p.ha = 50000; p.wb = 300000; p.hb = 30000;
			p.xb = 250000; p.yb = 100000;
			p.ra = 20'sd51472; p.rb = p.ra + 20'(k * 102944);
			send_request(p);
		end
		p.rb = 20'sd12345;
		send_request(p);
		p.ra = -20'sd300000;
		send_request(p);
		wait_drained();
	endtask

	task automatic test_random(int count);
		for (int n = 0; n < count; n++) send_request(random_pair($urandom_range(0, 4) != 0));
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		{center_x_a, center_y_a, width_a, height_a, angle_a} = '0;
		{center_x_b, center_y_b, width_b, height_b, angle_b} = '0;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_random(800);
		wait_drained();
		test_random(600);
		gaps_on = 0;
		test_random(250);
		wait_drained();
		$display("sent %0d rectangle pairs, checked %0d results (%0d overlapping)",
			requests_sent, results_seen, hits_seen);
		if (mismatches == 0 && overlap_queue.size() == 0)
			$display("rotated_rect_overlap_test_unit regression: pass");
		else
			$display("rotated_rect_overlap_test_unit regression: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("rotated_rect_overlap_test_unit regression: fail");
		$finish;
	end
endmodule

[rotated_rect_overlap_test_unit.f]
+incdir+sv
sv/rro_pkg.sv
sv/rro_cordic.sv
sv/rro_rotate.sv
sv/rro_sat.sv
sv/rotated_rect_overlap_test_unit.sv
bench/tb.sv
